>>> hdl/r2q_pkg.sv
// shared types and constants for the rotation matrix to quaternion block
`default_nettype none
package r2q_pkg;

	localparam int ElemW = 16;
	localparam int NumW  = 17;
	localparam int CompW = 16;
	localparam int CompMax = 32767;
	localparam int CompMinMag = 32768;

	// component that comes straight from the root
	typedef enum logic [1:0] {
		SEL_X = 2'd0,
		SEL_Y = 2'd1,
		SEL_Z = 2'd2,
		SEL_W = 2'd3
	} sel_t;

	typedef logic signed [NumW-1:0] num_t;

	// classified word: numerators still to be divided, in component order, chosen one skipped
	typedef struct packed {
		logic bad;
		sel_t sel;
		num_t na;
		num_t nb;
		num_t nc;
	} tag_t;

endpackage
`default_nettype wire

>>> hdl/r2q_front.sv
// front end: takes a matrix, picks the branch, forms radicand and numerators
`default_nettype none
module r2q_front #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [15:0]       r00,
	input  wire logic signed [15:0]       r01,
	input  wire logic signed [15:0]       r02,
	input  wire logic signed [15:0]       r10,
	input  wire logic signed [15:0]       r11,
	input  wire logic signed [15:0]       r12,
	input  wire logic signed [15:0]       r20,
	input  wire logic signed [15:0]       r21,
	input  wire logic signed [15:0]       r22,
	output logic                          f_valid,
	input  wire logic                     f_ready,
	output r2q_pkg::tag_t                 f_tag,
	output logic [((FRAC_BITS+2 > 19) ? FRAC_BITS+2 : 19)-2:0] f_rad
);
	localparam int RSW = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
	localparam int RW  = RSW - 1;
	localparam logic signed [RSW-1:0] ONE = {{(RSW-1){1'b0}}, 1'b1} << FRAC_BITS;

	logic signed [RSW-1:0] e00, e11, e22, trace, rad;
	logic                  tr_pos, bad;
	r2q_pkg::sel_t         sel;
	r2q_pkg::num_t         na, nb, nc;
	logic                  v_s1;
	r2q_pkg::tag_t         tag_s1;
	logic [RW-1:0]         rad_s1;

	always_comb begin
		e00 = RSW'(r00);
		e11 = RSW'(r11);
		e22 = RSW'(r22);
		trace = e00 + e11 + e22;
		tr_pos = (trace > 0);
		if (tr_pos) begin
			sel = r2q_pkg::SEL_W;
			rad = trace + ONE;
			na = 17'(r21) - 17'(r12);
			nb = 17'(r02) - 17'(r20);
			nc = 17'(r10) - 17'(r01);
		end else if ((r22 > r11 && r11 > r00) || (r22 > r00 && !(r11 > r00))) begin
			sel = r2q_pkg::SEL_Z;
			rad = e22 - e00 - e11 + ONE;
			na = 17'(r02) + 17'(r20);
			nb = 17'(r12) + 17'(r21);
			nc = 17'(r10) - 17'(r01);
		end else if (r11 > r00) begin
			sel = r2q_pkg::SEL_Y;
			rad = e11 - e22 - e00 + ONE;
			na = 17'(r01) + 17'(r10);
			nb = 17'(r21) + 17'(r12);
			nc = 17'(r02) - 17'(r20);
		end else begin
			sel = r2q_pkg::SEL_X;
			rad = e00 - e11 - e22 + ONE;
			na = 17'(r10) + 17'(r01);
			nb = 17'(r20) + 17'(r02);
			nc = 17'(r21) - 17'(r12);
		end
		bad = !tr_pos && (rad <= 0);
	end

	assign in_ready = !v_s1 || f_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tag_s1.bad <= bad;
			tag_s1.sel <= sel;
			tag_s1.na  <= na;
			tag_s1.nb  <= nb;
			tag_s1.nc  <= nc;
			rad_s1     <= rad[RW-1:0];
		end
	end

	assign f_valid = v_s1;
	assign f_tag   = tag_s1;
	assign f_rad   = rad_s1;
endmodule
`default_nettype wire

>>> hdl/r2q_queue.sv
// two-entry queue between front end and back end
`default_nettype none
module r2q_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);
	logic [W-1:0] data_q [0:1];
	logic         wptr_q, rptr_q;
	logic [1:0]   count_q;
	logic         push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = data_q[rptr_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) data_q[wptr_q] <= push_data;
	end
endmodule
`default_nettype wire

>>> hdl/r2q_back.sv
// back end: pipelined square root, three pipelined dividers, saturation
`default_nettype none
module r2q_back #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire r2q_pkg::tag_t           in_tag,
	input  wire logic [((FRAC_BITS+2 > 19) ? FRAC_BITS+2 : 19)-2:0] in_rad,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [15:0]           qx,
	output logic signed [15:0]           qy,
	output logic signed [15:0]           qz,
	output logic signed [15:0]           qw,
	output logic                         bad_radicand,
	output logic                         clipped
);
	localparam int RSW = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
	localparam int RW  = RSW - 1;
	localparam int VW  = RW + FRAC_BITS;
	localparam int RTW = (VW + 1) / 2;
	localparam int SW  = 2 * RTW;
	localparam int RMW = RTW + 2;
	localparam int DW  = RTW + 1;
	localparam int NW  = ((r2q_pkg::NumW + FRAC_BITS > RTW) ?
		r2q_pkg::NumW + FRAC_BITS : RTW) + 1;
	localparam int HW  = (RTW + 1 > 17) ? RTW + 1 : 17;

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// square root, one result bit per stage
	logic [SW-1:0]  sv_s   [0:RTW];
	logic [RMW-1:0] srem_s [0:RTW];
	logic [RTW-1:0] sres_s [0:RTW];
	r2q_pkg::tag_t  stag_s [0:RTW];
	logic           sval_s [0:RTW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sval_s[0] <= 1'b0;
		end else if (en) begin
			sval_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s[0]   <= SW'({in_rad, {FRAC_BITS{1'b0}}});
			srem_s[0] <= '0;
			sres_s[0] <= '0;
			stag_s[0] <= in_tag;
		end
	end

	for (genvar k = 0; k < RTW; k++) begin : g_sq
		logic [RMW+1:0] cat, sub, diff;
		logic           ge;
		always_comb begin
			cat  = {srem_s[k], sv_s[k][SW-1-2*k -: 2]};
			sub  = (RMW+2)'({sres_s[k], 2'b01});
			ge   = (cat >= sub);
			diff = cat - sub;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sval_s[k+1] <= 1'b0;
			end else if (en) begin
				sval_s[k+1] <= sval_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sv_s[k+1]   <= sv_s[k];
				srem_s[k+1] <= ge ? diff[RMW-1:0] : cat[RMW-1:0];
				sres_s[k+1] <= {sres_s[k][RTW-2:0], ge};
				stag_s[k+1] <= stag_s[k];
			end
		end
	end

	// dividers: ((|n| << frac) + root) / (2 * root), one quotient bit per stage
	logic [NW-1:0]  dnq_s  [0:2][0:NW];
	logic [DW-1:0]  drem_s [0:2][0:NW];
	logic [2:0]     dneg_s [0:NW];
	logic [RTW-1:0] droot_s [0:NW];
	r2q_pkg::tag_t  dtag_s [0:NW];
	logic           dval_s [0:NW];

	r2q_pkg::num_t  nsel [0:2];
	logic [r2q_pkg::NumW-1:0] nmag [0:2];
	logic [RTW-1:0] root;

	assign root = sres_s[RTW];

	always_comb begin
		nsel[0] = stag_s[RTW].na;
		nsel[1] = stag_s[RTW].nb;
		nsel[2] = stag_s[RTW].nc;
		for (int l = 0; l < 3; l++) begin
			nmag[l] = nsel[l][r2q_pkg::NumW-1] ? r2q_pkg::NumW'(-nsel[l]) : nsel[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dval_s[0] <= 1'b0;
		end else if (en) begin
			dval_s[0] <= sval_s[RTW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s[0]  <= {nsel[2][r2q_pkg::NumW-1], nsel[1][r2q_pkg::NumW-1],
				nsel[0][r2q_pkg::NumW-1]};
			droot_s[0] <= root;
			dtag_s[0]  <= stag_s[RTW];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_din
		always_ff @(posedge clk) begin
			if (en) begin
				dnq_s[l][0]  <= NW'({nmag[l], {FRAC_BITS{1'b0}}}) + NW'(root);
				drem_s[l][0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [DW:0] dsub;
		assign dsub = {droot_s[k], 1'b0};
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DW:0] cat, diff;
			logic        ge;
			always_comb begin
				cat  = {drem_s[l][k], dnq_s[l][k][NW-1]};
				ge   = (cat >= dsub);
				diff = cat - dsub;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					drem_s[l][k+1] <= ge ? diff[DW-1:0] : cat[DW-1:0];
					dnq_s[l][k+1]  <= {dnq_s[l][k][NW-2:0], ge};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dval_s[k+1] <= 1'b0;
			end else if (en) begin
				dval_s[k+1] <= dval_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dneg_s[k+1]  <= dneg_s[k];
				droot_s[k+1] <= droot_s[k];
				dtag_s[k+1]  <= dtag_s[k];
			end
		end
	end

	// saturation and placement
	logic [15:0] lane_v [0:2];
	logic [2:0]  lane_c;
	logic [HW-1:0] half;
	logic [15:0] half_v;
	logic        half_c;
	logic [15:0] comp [0:3];
	logic        clip_any;
	logic [NW-1:0] qmag;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qmag = dnq_s[l][NW];
			if (!dneg_s[NW][l]) begin
				lane_c[l] = (qmag > NW'(r2q_pkg::CompMax));
				lane_v[l] = lane_c[l] ? 16'h7fff : qmag[15:0];
			end else begin
				lane_c[l] = (qmag > NW'(r2q_pkg::CompMinMag));
				lane_v[l] = lane_c[l] ? 16'h8000 : 16'(-qmag[15:0]);
			end
		end
		half   = (HW'(droot_s[NW]) + HW'(1)) >> 1;
		half_c = (half > HW'(r2q_pkg::CompMax));
		half_v = half_c ? 16'h7fff : half[15:0];
		clip_any = half_c;
		for (int c = 0; c < 4; c++) begin
			if (2'(c) == dtag_s[NW].sel) begin
				comp[c] = half_v;
			end else if (2'(c) < dtag_s[NW].sel) begin
				comp[c] = lane_v[c];
				clip_any = clip_any | lane_c[c];
			end else begin
				comp[c] = lane_v[c-1];
				clip_any = clip_any | lane_c[c-1];
			end
		end
		qmag = '0;
	end

	logic        ov_q;
	logic [15:0] qx_q, qy_q, qz_q, qw_q;
	logic        bad_q, clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= dval_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_q <= dtag_s[NW].bad;
			if (dtag_s[NW].bad) begin
				qx_q   <= '0;
				qy_q   <= '0;
				qz_q   <= '0;
				qw_q   <= '0;
				clip_q <= 1'b0;
			end else begin
				qx_q   <= comp[0];
				qy_q   <= comp[1];
				qz_q   <= comp[2];
				qw_q   <= comp[3];
				clip_q <= clip_any;
			end
		end
	end

	assign out_valid    = ov_q;
	assign qx           = qx_q;
	assign qy           = qy_q;
	assign qz           = qz_q;
	assign qw           = qw_q;
	assign bad_radicand = bad_q;
	assign clipped      = clip_q;
endmodule
`default_nettype wire

>>> hdl/rotation_matrix_to_quaternion.sv
// top level: rotation matrix to unit quaternion, Shepperd's method
//
//  channel  signals                               direction
//  in       in_valid/in_ready, r00..r22           matrix words in
//  out      out_valid/out_ready, qx qy qz qw,     quaternion words out
//           bad_radicand, clipped
//
// one word per cycle sustained while output words are taken; a word passes the front
// register, the queue, a square root of one bit per stage and three dividers
// of one quotient bit per stage, then the output register.
// reset clears only valid flags and the queue's pointers and count; nothing to sweep.
// the back end pipeline advances as a whole whenever its output word is taken
// or empty; the queue lets the front end keep accepting during a short stall.
`default_nettype none
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] r00,
	input  wire logic signed [15:0] r01,
	input  wire logic signed [15:0] r02,
	input  wire logic signed [15:0] r10,
	input  wire logic signed [15:0] r11,
	input  wire logic signed [15:0] r12,
	input  wire logic signed [15:0] r20,
	input  wire logic signed [15:0] r21,
	input  wire logic signed [15:0] r22,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      qx,
	output logic signed [15:0]      qy,
	output logic signed [15:0]      qz,
	output logic signed [15:0]      qw,
	output logic                    bad_radicand,
	output logic                    clipped
);
	localparam int RSW = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
	localparam int RW  = RSW - 1;
	localparam int TW  = $bits(r2q_pkg::tag_t);
	localparam int QW  = TW + RW;

	logic          f_valid, f_ready, b_valid, b_ready;
	r2q_pkg::tag_t f_tag, b_tag;
	logic [RW-1:0] f_rad, b_rad;
	logic [QW-1:0] b_data;

	r2q_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.r00(r00), .r01(r01), .r02(r02),
		.r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.f_valid(f_valid), .f_ready(f_ready),
		.f_tag(f_tag), .f_rad(f_rad)
	);

	r2q_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready),
		.push_data({f_rad, f_tag}),
		.pop_valid(b_valid), .pop_ready(b_ready),
		.pop_data(b_data)
	);

	assign b_tag = b_data[TW-1:0];
	assign b_rad = b_data[QW-1:TW];

	r2q_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready),
		.in_tag(b_tag), .in_rad(b_rad),
		.out_valid(out_valid), .out_ready(out_ready),
		.qx(qx), .qy(qy), .qz(qz), .qw(qw),
		.bad_radicand(bad_radicand), .clipped(clipped)
	);
endmodule
`default_nettype wire
